@@ rtl/dpxc_pkg.sv @@
// Shared constants, types and helper functions of the dual-polarization cross-correlator.
`default_nettype none
package dpxc_pkg;

  localparam int STATIONS  = 16;
  localparam int CHANNELS  = 16;
  localparam int NBASE     = STATIONS * (STATIONS + 1) / 2;
  localparam int ROWS      = CHANNELS * NBASE;
  localparam int ROW_AW    = $clog2(ROWS);
  localparam int ST_W      = $clog2(STATIONS);
  localparam int SMP_W     = 16;
  localparam int PROD_W    = 2 * SMP_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int ACC_W     = 48;
  localparam int LANE_W    = 2 * ACC_W;
  localparam int NPP       = 4;
  localparam int ROW_W     = NPP * LANE_W;
  localparam int DRAIN_CYC = 3;

  typedef enum logic [1:0] {
    OP_ACC   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ACC,
    S_DRAIN,
    S_READ,
    S_RWAIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic              load;      // capture the command at transfer
    logic              issue;     // start one baseline of an accumulate
    logic              rd_issue;  // read row for a visibility read
    logic              out_load;  // register the read result
    logic              clr_we;    // write zero row during clearing pass
    logic [ROW_AW-1:0] idx;       // baseline index or clear address
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic            acc_ok;      // accumulate target in range
    logic [ST_W-1:0] station;     // station of the held command
  } dp_stat_t;

  // first row of station s within one channel: s*(s+1)/2
  function automatic logic [ROW_AW-1:0] tri_base(input logic [ST_W-1:0] s);
    logic [ROW_AW-1:0] sx;
    sx = ROW_AW'(s);
    return ROW_AW'((sx * (sx + ROW_AW'(1))) >> 1);
  endfunction

endpackage
`default_nettype wire

@@ rtl/dpxc_ctrl.sv @@
// Controller state machine: sequences clear sweeps, accumulates and reads.
`default_nettype none
module dpxc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [1:0]        opcode,
  input  wire dpxc_pkg::dp_stat_t stat,
  output dpxc_pkg::dp_cmd_t      cmd,
  output logic                   busy
);
  import dpxc_pkg::*;

  state_t            state_r, state_nxt;
  logic [ROW_AW-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.idx   = cnt_r;
    busy      = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (cnt_r == ROW_AW'(ROWS - 1)) begin
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + ROW_AW'(1);
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          cnt_nxt  = '0;
          case (opcode)
            OP_ACC:   if (stat.acc_ok) state_nxt = S_ACC;
            OP_READ:  state_nxt = S_READ;
            OP_CLEAR: state_nxt = S_CLEAR;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_ACC: begin
        cmd.issue = 1'b1;
        if (cnt_r == ROW_AW'(stat.station)) begin
          state_nxt = S_DRAIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + ROW_AW'(1);
        end
      end
      S_DRAIN: begin
        if (cnt_r == ROW_AW'(DRAIN_CYC - 1)) begin
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + ROW_AW'(1);
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_RWAIT;
      end
      S_RWAIT: begin
        cmd.out_load = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/dpxc_dp.sv @@
// Datapath: row store, accumulator memory and four-lane complex MAC pipeline.
`default_nettype none
module dpxc_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire dpxc_pkg::dp_cmd_t               cmd,
  output dpxc_pkg::dp_stat_t                   stat,
  input  wire logic [1:0]                      in_opcode,
  input  wire logic [3:0]                      in_channel,
  input  wire logic [3:0]                      in_station,
  input  wire logic [3:0]                      in_other_station,
  input  wire logic [1:0]                      in_pol_pair,
  input  wire logic signed [dpxc_pkg::SMP_W-1:0] in_x_re,
  input  wire logic signed [dpxc_pkg::SMP_W-1:0] in_x_im,
  input  wire logic signed [dpxc_pkg::SMP_W-1:0] in_y_re,
  input  wire logic signed [dpxc_pkg::SMP_W-1:0] in_y_im,
  output logic                                 out_valid,
  output logic signed [dpxc_pkg::ACC_W-1:0]    out_vis_re,
  output logic signed [dpxc_pkg::ACC_W-1:0]    out_vis_im,
  output logic                                 out_status
);
  import dpxc_pkg::*;

  localparam logic [ROW_AW-1:0] NBASE_A = ROW_AW'(NBASE);
  localparam logic signed [ACC_W:0] SAT_MAX = {2'b00, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W:0] SAT_MIN = {2'b11, {(ACC_W-1){1'b0}}};

  // held command
  logic [ROW_AW-1:0] base_r;
  logic [ST_W-1:0]   station_r;
  logic [ROW_AW-1:0] other_r;
  logic [1:0]        pp_r;
  logic              bad_r;
  logic [4*SMP_W-1:0] smp_a_r;

  logic [4*SMP_W-1:0] row_r [STATIONS];

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROW_W-1:0] rd_q_r;

  // MAC pipeline
  logic                     v1_r, v2_r, v3_r;
  logic [ROW_AW-1:0]        addr1_r, addr2_r, addr3_r;
  logic [4*SMP_W-1:0]       smp_b_r;
  logic signed [PROD_W-1:0] prod_r [4*NPP];
  logic signed [PROD_W-1:0] prod_nxt [4*NPP];
  logic [ROW_W-1:0]         acc2_r, acc3_r;
  logic signed [SUM_W-1:0]  sre_r [NPP];
  logic signed [SUM_W-1:0]  sim_r [NPP];
  logic [ROW_W-1:0]         wdata;

  logic                     out_valid_r, out_status_r;
  logic signed [ACC_W-1:0]  vis_re_r, vis_im_r;

  logic              in_ok, rd_bad;
  logic [ROW_AW-1:0] base_nxt;
  logic              re, we;
  logic [ROW_AW-1:0] raddr, waddr;
  logic [ROW_W-1:0]  mem_wdata;
  logic [LANE_W-1:0] lane;

  assign in_ok    = (32'(in_channel) < CHANNELS) && (32'(in_station) < STATIONS);
  assign rd_bad   = !in_ok || (in_other_station > in_station);
  assign base_nxt = ROW_AW'(ROW_AW'(in_channel) * NBASE_A) + tri_base(ST_W'(in_station));

  assign stat.acc_ok  = in_ok;
  assign stat.station = station_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r    <= base_nxt;
      station_r <= ST_W'(in_station);
      other_r   <= ROW_AW'(in_other_station);
      pp_r      <= in_pol_pair;
      bad_r     <= rd_bad;
      smp_a_r   <= {in_y_im, in_y_re, in_x_im, in_x_re};
    end
  end

  // row store: current instant of each station
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STATIONS; i++) row_r[i] <= '0;
    end else if (cmd.load && in_opcode == OP_ACC && in_ok) begin
      row_r[ST_W'(in_station)] <= {in_y_im, in_y_re, in_x_im, in_x_re};
    end
  end

  // accumulator memory, one row per channel and baseline
  assign re        = cmd.issue || (cmd.rd_issue && !bad_r);
  assign raddr     = cmd.issue ? base_r + cmd.idx : base_r + other_r;
  assign we        = cmd.clr_we || v3_r;
  assign waddr     = cmd.clr_we ? cmd.idx : addr3_r;
  assign mem_wdata = cmd.clr_we ? '0 : wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= mem_wdata;
    if (re) rd_q_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // products: lane pp = p1*2+p2 -> ar*br, ai*bi, ai*br, ar*bi
  always_comb begin
    for (int pp = 0; pp < NPP; pp++) begin
      prod_nxt[4*pp+0] = $signed(smp_a_r[(pp/2)*32 +: 16]) * $signed(smp_b_r[(pp%2)*32 +: 16]);
      prod_nxt[4*pp+1] = $signed(smp_a_r[(pp/2)*32+16 +: 16])
                       * $signed(smp_b_r[(pp%2)*32+16 +: 16]);
      prod_nxt[4*pp+2] = $signed(smp_a_r[(pp/2)*32+16 +: 16])
                       * $signed(smp_b_r[(pp%2)*32 +: 16]);
      prod_nxt[4*pp+3] = $signed(smp_a_r[(pp/2)*32 +: 16])
                       * $signed(smp_b_r[(pp%2)*32+16 +: 16]);
    end
  end

  always_ff @(posedge clk) begin
    smp_b_r <= row_r[cmd.idx[ST_W-1:0]];
    addr1_r <= raddr;
    for (int k = 0; k < 4*NPP; k++) prod_r[k] <= prod_nxt[k];
    acc2_r  <= rd_q_r;
    addr2_r <= addr1_r;
    for (int pp = 0; pp < NPP; pp++) begin
      sre_r[pp] <= SUM_W'(prod_r[4*pp+0]) + SUM_W'(prod_r[4*pp+1]);
      sim_r[pp] <= SUM_W'(prod_r[4*pp+2]) - SUM_W'(prod_r[4*pp+3]);
    end
    acc3_r  <= acc2_r;
    addr3_r <= addr2_r;
  end

  // saturating accumulate
  always_comb begin
    logic signed [ACC_W:0] s_re, s_im;
    for (int pp = 0; pp < NPP; pp++) begin
      s_re = (ACC_W+1)'($signed(acc3_r[pp*LANE_W +: ACC_W])) + (ACC_W+1)'(sre_r[pp]);
      s_im = (ACC_W+1)'($signed(acc3_r[pp*LANE_W+ACC_W +: ACC_W])) + (ACC_W+1)'(sim_r[pp]);
      if (s_re > SAT_MAX)      s_re = SAT_MAX;
      else if (s_re < SAT_MIN) s_re = SAT_MIN;
      if (s_im > SAT_MAX)      s_im = SAT_MAX;
      else if (s_im < SAT_MIN) s_im = SAT_MIN;
      wdata[pp*LANE_W +: LANE_W] = {s_im[ACC_W-1:0], s_re[ACC_W-1:0]};
    end
  end

  // read result
  assign lane = rd_q_r[pp_r*LANE_W +: LANE_W];

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= cmd.out_load;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= bad_r;
      vis_re_r     <= bad_r ? '0 : $signed(lane[ACC_W-1:0]);
      vis_im_r     <= bad_r ? '0 : $signed(lane[LANE_W-1:ACC_W]);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_vis_re = vis_re_r;
  assign out_vis_im = vis_im_r;

endmodule
`default_nettype wire

@@ rtl/dual_pol_cross_correlator_top.sv @@
// Top level of the dual-polarization cross-correlator (X stage).
//
// Command channel: a transfer happens at a clock edge with start high and
// busy low. in_opcode selects accumulate, read or clear; opcode 3 is ignored.
// Accumulate writes the X/Y sample into the row store under its station,
// then walks baselines b = 0..station, one per cycle, with four complex
// multiply-accumulates (one per polarization pair) per baseline.
// Accumulators are 48-bit and saturate.
// What bounds each command until the next transfer can happen:
//   accumulate: the walk over baselines 0..station through the one-row-per-cycle
//               port of the accumulator memory, plus the MAC pipeline drain.
//   read:       states READ then RWAIT; out_valid then pulses for one cycle.
//   clear:      a sweep over every row, writing one zero row per cycle.
// Result channel: out_valid strobes for exactly one cycle with out_vis_re,
// out_vis_im and out_status; the receiver cannot stall it. A bad read
// (other_station above station, or out of range) gives status 1 and zeros.
// Reset (rst_n low, synchronous) zeroes the row store and starts the same
// clearing sweep; busy stays high until it completes.
`default_nettype none
module dual_pol_cross_correlator_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        in_opcode,
  input  wire logic [3:0]                        in_channel,
  input  wire logic [3:0]                        in_station,
  input  wire logic [3:0]                        in_other_station,
  input  wire logic [1:0]                        in_pol_pair,
  input  wire logic signed [dpxc_pkg::SMP_W-1:0] in_x_re,
  input  wire logic signed [dpxc_pkg::SMP_W-1:0] in_x_im,
  input  wire logic signed [dpxc_pkg::SMP_W-1:0] in_y_re,
  input  wire logic signed [dpxc_pkg::SMP_W-1:0] in_y_im,
  output logic                                   out_valid,
  output logic signed [dpxc_pkg::ACC_W-1:0]      out_vis_re,
  output logic signed [dpxc_pkg::ACC_W-1:0]      out_vis_im,
  output logic                                   out_status
);
  import dpxc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing
  dpxc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  // storage and arithmetic
  dpxc_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_opcode        (in_opcode),
    .in_channel       (in_channel),
    .in_station       (in_station),
    .in_other_station (in_other_station),
    .in_pol_pair      (in_pol_pair),
    .in_x_re          (in_x_re),
    .in_x_im          (in_x_im),
    .in_y_re          (in_y_re),
    .in_y_im          (in_y_im),
    .out_valid        (out_valid),
    .out_vis_re       (out_vis_re),
    .out_vis_im       (out_vis_im),
    .out_status       (out_status)
  );

endmodule
`default_nettype wire

@@ rtl/dpxc_chk.sv @@
// Port-level assertion checker for the cross-correlator, bound to the top level.
`default_nettype none
module dpxc_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  in_opcode,
  input wire logic        out_valid,
  input wire logic [47:0] out_vis_re,
  input wire logic [47:0] out_vis_im,
  input wire logic        out_status
);
  import dpxc_pkg::*;

  // reset launches the clearing sweep
  a_rst_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // a read transfer yields its strobe
  a_rd_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == OP_READ) |-> ##3 out_valid)
    else $error("read result missing");

  // other commands never produce a result
  a_no_res: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode != OP_READ) |-> ##3 !out_valid)
    else $error("result from a non-read command");

  // bad request returns zeros
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_vis_re == '0 && out_vis_im == '0))
    else $error("bad read with nonzero visibility");

endmodule

bind dual_pol_cross_correlator_top dpxc_chk u_dpxc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_opcode  (in_opcode),
  .out_valid  (out_valid),
  .out_vis_re (out_vis_re),
  .out_vis_im (out_vis_im),
  .out_status (out_status)
);
`default_nettype wire
